>>> sv/lnh_pkg.sv
// shared types, constants and saturation helpers for the heun-step neuron
`timescale 1ns / 1ps
`default_nettype none

package lnh_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic signed [VALUE_WIDTH-1:0] DP_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_WIDTH-1:0] DP_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_WIDTH-1:0] FX_ONE = 32'sh0001_0000;
  // -70 mV
  localparam logic signed [VALUE_WIDTH-1:0] V_INIT = -32'sd4587520;

  localparam logic [30:0]        DT_RST     = 31'd6554;
  localparam logic [30:0]        CAP_RST    = 31'd65536;
  localparam logic [30:0]        RM_RST     = 31'd1310720;
  localparam logic signed [31:0] VREST_RST  = -32'sd4587520;
  localparam logic signed [31:0] VTH_RST    = -32'sd3276800;
  localparam logic signed [31:0] VRESET_RST = -32'sd4587520;
  localparam logic [30:0]        TREF_RST   = 31'd327680;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP   = 3'd0,
    CFG_CAPACITANCE = 3'd1,
    CFG_RESISTANCE  = 3'd2,
    CFG_REST        = 3'd3,
    CFG_THRESHOLD   = 3'd4,
    CFG_RESET       = 3'd5,
    CFG_REFRACTORY  = 3'd6
  } lnh_cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MAG,
    ST_DSET,
    ST_DIV,
    ST_DFIN,
    ST_MUL,
    ST_MRND,
    ST_POST,
    ST_SUM,
    ST_DONE
  } lnh_state_e;

  typedef enum logic [3:0] {
    PH_K0_R,
    PH_K0_C,
    PH_V1,
    PH_K1_PRE,
    PH_K1_R,
    PH_K1_C,
    PH_VN,
    PH_TEST,
    PH_RATIO,
    PH_BACK
  } lnh_phase_e;

  // clamp a 33-bit sum to the 32-bit datapath
  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    if (x[32] != x[31]) begin
      return x[32] ? DP_MIN : DP_MAX;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  // apply sign to a magnitude and clamp
  function automatic logic signed [31:0] sat_mag(input logic [47:0] m, input logic neg);
    if (neg) begin
      if (m >= 48'h0000_8000_0000) begin
        return DP_MIN;
      end
      return 32'(-m[31:0]);
    end
    if (m > 48'h0000_7FFF_FFFF) begin
      return DP_MAX;
    end
    return m[31:0];
  endfunction

  function automatic logic is_div(input lnh_phase_e ph);
    return (ph == PH_K0_R) || (ph == PH_K0_C) || (ph == PH_K1_R) ||
           (ph == PH_K1_C) || (ph == PH_RATIO);
  endfunction

endpackage

`default_nettype wire

>>> sv/lnh_if.sv
// handshake channels for neuron tick input and step result
`timescale 1ns / 1ps
`default_nettype none

interface lnh_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] now_time;
  logic signed [31:0] prior_spike_time;
  logic signed [31:0] syn_current_start;
  logic signed [31:0] axial_current_start;
  logic signed [31:0] electrode_current_start;
  logic signed [31:0] syn_current_end;
  logic signed [31:0] axial_current_end;
  logic signed [31:0] electrode_current_end;

  modport source (
    output valid, now_time, prior_spike_time,
    output syn_current_start, axial_current_start, electrode_current_start,
    output syn_current_end, axial_current_end, electrode_current_end,
    input  ready
  );
  modport sink (
    input  valid, now_time, prior_spike_time,
    input  syn_current_start, axial_current_start, electrode_current_start,
    input  syn_current_end, axial_current_end, electrode_current_end,
    output ready
  );
endinterface

interface lnh_out_if;
  logic               valid;
  logic               ready;
  logic               fired;
  logic signed [31:0] fire_time;
  logic signed [31:0] membrane_voltage;

  modport source (
    output valid, fired, fire_time, membrane_voltage,
    input  ready
  );
  modport sink (
    input  valid, fired, fire_time, membrane_voltage,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/lif_neuron_heun_step.sv
// leaky integrate-and-fire neuron, one heun step per input beat
//
// in_i carries one tick: current time, last spike time and the synaptic,
// axial and electrode currents at step start and end. out_o returns one
// beat per tick: fired flag, interpolated spike time, new membrane voltage.
// the membrane potential lives inside the block and starts at -70 mV.
// registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must write them only while idle, the block itself does not enforce this.
// one radix-2 divider (one quotient bit per cycle) and one 32x32 multiplier
// are shared under a small sequencer; its divisions, up to five, dominate.
// in_i.ready is high only while the sequencer is idle, so a new tick is not
// accepted until the previous one has been written to the output register.
// the result sits in an output register; the next tick is accepted while it
// waits, and a finished tick holds in its last state until out_o.ready frees
// the register. reset restores register defaults and the -70 mV potential.
`timescale 1ns / 1ps
`default_nettype none

module lif_neuron_heun_step
  import lnh_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i,
  lnh_in_if.sink                    in_i,
  lnh_out_if.source                 out_o
);

  // configuration
  logic [30:0]        dt_q, cap_q, rm_q, tref_q;
  logic signed [31:0] vrest_q, vth_q, vreset_q;

  // control
  lnh_state_e         state_q, state_d;
  lnh_phase_e         phase_q, phase_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] v_q, v_d;

  // tick payload
  logic signed [31:0] now_q, prior_q;
  logic signed [31:0] cur_q [6];

  // shared unit
  logic signed [32:0] opa_q, opa_d, opb_q, opb_d;
  logic [32:0]        ma_q, ma_d, mb_q, mb_d;
  logic               neg_q, neg_d, aneg_q, aneg_d;
  logic [31:0]        rem_q, rem_d, quo_q, quo_d;
  logic               ovf_q, ovf_d, dz_q, dz_d;
  logic [63:0]        prod_q, prod_d;
  logic               hib_q, hib_d;
  logic signed [31:0] opres_q, opres_d;
  logic signed [31:0] acc_q, acc_d, k0_q, k0_d;
  logic               pf_q, pf_d;
  logic signed [31:0] pt_q, pt_d;

  // output register
  logic               fired_q, fired_d;
  logic signed [31:0] ftime_q, ftime_d, volt_q, volt_d;

  logic               in_acc;
  assign in_acc = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q     <= DT_RST;
      cap_q    <= CAP_RST;
      rm_q     <= RM_RST;
      vrest_q  <= VREST_RST;
      vth_q    <= VTH_RST;
      vreset_q <= VRESET_RST;
      tref_q   <= TREF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIME_STEP:   dt_q     <= cfg_data_i[30:0];
        CFG_CAPACITANCE: cap_q    <= cfg_data_i[30:0];
        CFG_RESISTANCE:  rm_q     <= cfg_data_i[30:0];
        CFG_REST:        vrest_q  <= cfg_data_i;
        CFG_THRESHOLD:   vth_q    <= cfg_data_i;
        CFG_RESET:       vreset_q <= cfg_data_i;
        CFG_REFRACTORY:  tref_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_K0_R;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      v_q         <= V_INIT;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      v_q         <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q    <= in_i.now_time;
      prior_q  <= in_i.prior_spike_time;
      cur_q[0] <= in_i.syn_current_start;
      cur_q[1] <= in_i.axial_current_start;
      cur_q[2] <= in_i.electrode_current_start;
      cur_q[3] <= in_i.syn_current_end;
      cur_q[4] <= in_i.axial_current_end;
      cur_q[5] <= in_i.electrode_current_end;
    end
    opa_q   <= opa_d;
    opb_q   <= opb_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    neg_q   <= neg_d;
    aneg_q  <= aneg_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    ovf_q   <= ovf_d;
    dz_q    <= dz_d;
    prod_q  <= prod_d;
    hib_q   <= hib_d;
    opres_q <= opres_d;
    acc_q   <= acc_d;
    k0_q    <= k0_d;
    pf_q    <= pf_d;
    pt_q    <= pt_d;
    fired_q <= fired_d;
    ftime_q <= ftime_d;
    volt_q  <= volt_d;
  end

  logic signed [33:0] age;
  logic [47:0]        dnum;
  logic [32:0]        rem2, rdiff;
  logic               ge;
  logic [63:0]        pfull;
  logic [47:0]        pround;
  logic signed [31:0] cur_sel, sum_s;
  logic [2:0]         cur_idx;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    v_d         = v_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    neg_d       = neg_q;
    aneg_d      = aneg_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    ovf_d       = ovf_q;
    dz_d        = dz_q;
    prod_d      = prod_q;
    hib_d       = hib_q;
    opres_d     = opres_q;
    acc_d       = acc_q;
    k0_d        = k0_q;
    pf_d        = pf_q;
    pt_d        = pt_q;
    fired_d     = fired_q;
    ftime_d     = ftime_q;
    volt_d      = volt_q;

    age    = {{2{now_q[31]}}, now_q} - {{2{prior_q[31]}}, prior_q};
    dnum   = {ma_q[31:0], 16'h0000} + {17'h0_0000, mb_q[31:1]};
    rem2   = {rem_q, quo_q[31]};
    rdiff  = rem2 - {1'b0, mb_q[31:0]};
    ge     = rem2 >= {1'b0, mb_q[31:0]};
    pfull  = hib_q ? {ma_q[31:0], 32'h0000_0000} : prod_q;
    // the averaged slope k0+k1 carries one more fraction bit
    pround = (phase_q == PH_VN) ?
             ({1'b0, pfull[63:17]} + {47'h0, pfull[16]}) :
             (pfull[63:16] + {47'h0, pfull[15]});
    cur_idx = (phase_q == PH_K1_R) ? (3'd3 + {1'b0, cnt_q[1:0]}) : {1'b0, cnt_q[1:0]};
    cur_sel = cur_q[cur_idx];
    sum_s   = sat_add(acc_q, cur_sel);

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (age > $signed({3'b000, tref_q})) begin
          opa_d   = 33'(sat_sub(vrest_q, v_q));
          opb_d   = {2'b00, rm_q};
          phase_d = PH_K0_R;
          state_d = ST_MAG;
        end else begin
          v_d     = vreset_q;
          pf_d    = 1'b0;
          pt_d    = '0;
          state_d = ST_DONE;
        end
      end

      ST_MAG: begin
        ma_d    = opa_q[32] ? 33'(-opa_q) : 33'(opa_q);
        mb_d    = opb_q[32] ? 33'(-opb_q) : 33'(opb_q);
        neg_d   = opa_q[32] ^ opb_q[32];
        aneg_d  = opa_q[32];
        state_d = is_div(phase_q) ? ST_DSET : ST_MUL;
      end

      ST_DSET: begin
        rem_d   = {16'h0000, dnum[47:32]};
        quo_d   = dnum[31:0];
        ovf_d   = {16'h0000, dnum[47:32]} >= mb_q[31:0];
        dz_d    = (mb_q[31:0] == 32'h0);
        cnt_d   = '0;
        state_d = ST_DIV;
      end

      ST_DIV: begin
        rem_d = ge ? rdiff[31:0] : rem2[31:0];
        quo_d = {quo_q[30:0], ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = ST_DFIN;
        end
      end

      ST_DFIN: begin
        if (dz_q) begin
          if (ma_q == '0) begin
            opres_d = '0;
          end else begin
            opres_d = aneg_q ? DP_MIN : DP_MAX;
          end
        end else begin
          opres_d = sat_mag({ovf_q, 15'h0000, quo_q}, neg_q);
        end
        state_d = ST_POST;
      end

      ST_MUL: begin
        prod_d  = ma_q[31:0] * mb_q[31:0];
        hib_d   = mb_q[32];
        state_d = ST_MRND;
      end

      ST_MRND: begin
        opres_d = sat_mag(pround, neg_q);
        state_d = ST_POST;
      end

      ST_SUM: begin
        acc_d = sum_s;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q[1:0] == 2'd2) begin
          opa_d   = 33'(sum_s);
          opb_d   = {2'b00, cap_q};
          phase_d = (phase_q == PH_K0_R) ? PH_K0_C : PH_K1_C;
          state_d = ST_MAG;
        end
      end

      ST_POST: begin
        case (phase_q)
          PH_K0_R, PH_K1_R: begin
            acc_d   = opres_q;
            cnt_d   = '0;
            state_d = ST_SUM;
          end
          PH_K0_C: begin
            k0_d    = opres_q;
            opa_d   = {2'b00, dt_q};
            opb_d   = 33'(opres_q);
            phase_d = PH_V1;
            state_d = ST_MAG;
          end
          PH_V1: begin
            acc_d   = sat_add(v_q, opres_q);
            phase_d = PH_K1_PRE;
          end
          PH_K1_PRE: begin
            opa_d   = 33'(sat_sub(vrest_q, acc_q));
            opb_d   = {2'b00, rm_q};
            phase_d = PH_K1_R;
            state_d = ST_MAG;
          end
          PH_K1_C: begin
            // unsaturated sum of both slopes
            opa_d   = {2'b00, dt_q};
            opb_d   = 33'(k0_q) + 33'(opres_q);
            phase_d = PH_VN;
            state_d = ST_MAG;
          end
          PH_VN: begin
            acc_d   = sat_add(v_q, opres_q);
            phase_d = PH_TEST;
          end
          PH_TEST: begin
            if (acc_q > vth_q) begin
              opa_d   = 33'(sat_sub(vth_q, v_q));
              opb_d   = 33'(sat_sub(acc_q, v_q));
              phase_d = PH_RATIO;
              state_d = ST_MAG;
            end else begin
              v_d     = acc_q;
              pf_d    = 1'b0;
              pt_d    = '0;
              state_d = ST_DONE;
            end
          end
          PH_RATIO: begin
            opa_d   = {2'b00, dt_q};
            opb_d   = 33'(sat_sub(FX_ONE, opres_q));
            phase_d = PH_BACK;
            state_d = ST_MAG;
          end
          PH_BACK: begin
            pt_d    = sat_sub(now_q, opres_q);
            pf_d    = 1'b1;
            v_d     = vreset_q;
            state_d = ST_DONE;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          fired_d     = pf_q;
          ftime_d     = pt_q;
          volt_d      = v_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_i.ready             = (state_q == ST_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.fired            = fired_q;
  assign out_o.fire_time        = ftime_q;
  assign out_o.membrane_voltage = volt_q;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for lif_neuron_heun_step: random ticks, register sweeps, heun predictor
`timescale 1ns / 1ps

module testbench;
  import lnh_pkg::*;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam longint Q_ONE = 64'sd65536;
  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;
  localparam logic [31:0] SIGNED_TOP = 32'h7FFF_FFFF;
  localparam logic [31:0] SIGNED_BOTTOM = 32'h8000_0000;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] now_time;
    logic signed [31:0] last_spike;
    logic signed [31:0] syn_0;
    logic signed [31:0] axial_0;
    logic signed [31:0] elec_0;
    logic signed [31:0] syn_1;
    logic signed [31:0] axial_1;
    logic signed [31:0] elec_1;
  } tick_t;

  typedef struct packed {
    logic               fired;
    logic signed [31:0] fire_time;
    logic signed [31:0] vmem;
  } step_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [31:0]          cfg_data;

  lnh_in_if  tick_ch ();
  lnh_out_if step_ch ();

  lif_neuron_heun_step i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (tick_ch.sink),
    .out_o      (step_ch.source)
  );

  // register copy and membrane state of the predictor
  longint dt_r, cap_r, rm_r, vrest_r, vth_r, vreset_r, tref_r, vmem_r;
  longint t_cursor;

  tick_t tick_queue[$];
  step_t step_expect[$];
  tick_t tick_held;

  int  n_ticks, n_steps, n_spikes, n_held, n_bad, n_settings, n_sent;
  int  burst_left, gap_left, rx_left;
  bit  hold_off, no_idle, rx_stall;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clip(longint x);
    if (x > Q_MAX) return Q_MAX;
    if (x < Q_MIN) return Q_MIN;
    return x;
  endfunction

  function automatic longint unsigned magnitude(longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint apply_sign(longint unsigned m, bit neg);
    if (m > 64'h1_0000_0000) m = 64'h1_0000_0000;
    return clip(neg ? -longint'(m) : longint'(m));
  endfunction

  // rounded fixed point product, ties away from zero
  function automatic longint fx_product(longint a, longint b, int unsigned extra);
    int unsigned   sh;
    longint unsigned p, q;
    sh = FRAC_BITS + extra;
    p = magnitude(a) * magnitude(b);
    q = (p >> sh) + ((p >> (sh - 1)) & 64'd1);
    return apply_sign(q, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_quotient(longint a, longint b);
    longint unsigned ma, mb, q;
    ma = magnitude(a);
    mb = magnitude(b);
    if (mb == 0) begin
      if (ma == 0) return 0;
      return (a < 0) ? Q_MIN : Q_MAX;
    end
    q = ((ma << FRAC_BITS) + mb / 2) / mb;
    return apply_sign(q, (a < 0) != (b < 0));
  endfunction

  function automatic longint dvdt(longint v, logic signed [31:0] i1,
                                  logic signed [31:0] i2, logic signed [31:0] i3);
    longint s;
    s = fx_quotient(clip(vrest_r - v), rm_r);
    s = clip(s + i1);
    s = clip(s + i2);
    s = clip(s + i3);
    return fx_quotient(s, cap_r);
  endfunction

  function automatic step_t heun_step(tick_t t);
    longint now, v0, k0, k1, v1, vn, ratio, back;
    step_t  r;
    now = longint'(t.now_time);
    v0 = vmem_r;
    r = '0;
    // exact difference, no wrap
    if (now - longint'(t.last_spike) > tref_r) begin
      k0 = dvdt(v0, t.syn_0, t.axial_0, t.elec_0);
      v1 = clip(v0 + fx_product(dt_r, k0, 0));
      k1 = dvdt(v1, t.syn_1, t.axial_1, t.elec_1);
      vn = clip(v0 + fx_product(dt_r, k0 + k1, 1));
      if (vn > vth_r) begin
        ratio = fx_quotient(clip(vth_r - v0), clip(vn - v0));
        back = fx_product(dt_r, clip(Q_ONE - ratio), 0);
        r.fired = 1'b1;
        r.fire_time = 32'(clip(now - back));
        vn = vreset_r;
      end
      vmem_r = vn;
    end else begin
      vmem_r = vreset_r;
      n_held++;
    end
    r.vmem = 32'(vmem_r);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic tick_t tick_of(logic signed [31:0] now, logic signed [31:0] last,
                                    logic signed [31:0] s0, logic signed [31:0] a0,
                                    logic signed [31:0] e0, logic signed [31:0] s1,
                                    logic signed [31:0] a1, logic signed [31:0] e1);
    tick_t t;
    t = '{now, last, s0, a0, e0, s1, a1, e1};
    return t;
  endfunction

  function automatic logic signed [31:0] pick_current();
    int unsigned        span;
    logic signed [31:0] c;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom;
      2: return $urandom_range(0, 1) ? SIGNED_TOP : SIGNED_BOTTOM;
      default: begin
        span = $urandom_range(10, 27);
        c = $urandom_range(0, 32'd1 << span);
        if ($urandom_range(0, 1)) c = -c;
        return c;
      end
    endcase
  endfunction

  function automatic tick_t make_tick();
    tick_t       t;
    int unsigned shape;
    longint      nxt, gap, pr;
    nxt = t_cursor + dt_r;
    t_cursor = longint'($signed(nxt[31:0]));
    t.now_time = t_cursor[31:0];
    shape = $urandom_range(0, 99);
    if (shape < 70) begin
      // a plausible tick: time advances by dt, last spike near the refractory edge
      case ($urandom_range(0, 5))
        0: gap = tref_r;
        1: gap = tref_r + 1;
        2: gap = $urandom_range(0, 32'(tref_r));
        default: gap = tref_r + $urandom_range(1, 1 << 22);
      endcase
      pr = t_cursor - gap;
      t.last_spike = pr[31:0];
      t.syn_0 = pick_current();
      t.axial_0 = pick_current();
      t.elec_0 = pick_current();
      if ($urandom_range(0, 1)) begin
        t.syn_1 = t.syn_0;
        t.axial_1 = t.axial_0;
        t.elec_1 = t.elec_0;
      end else begin
        t.syn_1 = pick_current();
        t.axial_1 = pick_current();
        t.elec_1 = pick_current();
      end
    end else if (shape < 90) begin
      t.last_spike = $urandom;
      t.syn_0 = pick_current();
      t.axial_0 = pick_current();
      t.elec_0 = pick_current();
      t.syn_1 = pick_current();
      t.axial_1 = pick_current();
      t.elec_1 = pick_current();
    end else begin
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end
    return t;
  endfunction

  task automatic drain();
    while (tick_queue.size() != 0 || tick_ch.valid || step_expect.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TIME_STEP:   dt_r = val[30:0];
      CFG_CAPACITANCE: cap_r = val[30:0];
      CFG_RESISTANCE:  rm_r = val[30:0];
      CFG_REST:        vrest_r = longint'($signed(val));
      CFG_THRESHOLD:   vth_r = longint'($signed(val));
      CFG_RESET:       vreset_r = longint'($signed(val));
      CFG_REFRACTORY:  tref_r = val[30:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] dt, input logic [31:0] cap,
                           input logic [31:0] rm, input logic [31:0] vrest,
                           input logic [31:0] vth, input logic [31:0] vreset,
                           input logic [31:0] tref);
    write_reg(CFG_TIME_STEP, dt);
    write_reg(CFG_CAPACITANCE, cap);
    write_reg(CFG_RESISTANCE, rm);
    write_reg(CFG_REST, vrest);
    write_reg(CFG_THRESHOLD, vth);
    write_reg(CFG_RESET, vreset);
    write_reg(CFG_REFRACTORY, tref);
  endtask

  task automatic write_random_regs(input bit wild);
    logic signed [31:0] vrest, vth, vreset;
    if (wild) begin
      write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      vrest = -$signed($urandom_range(0, 100 << 16));
      // threshold mostly above rest, sometimes lowered beneath it
      vth = ($urandom_range(0, 3) == 0) ? vrest - $signed($urandom_range(0, 20 << 16)) :
                                          vrest + $signed($urandom_range(0, 40 << 16));
      vreset = vrest - $signed($urandom_range(0, 10 << 16));
      write_all({1'($urandom), 31'($urandom_range(655, 65536))},
                $urandom_range(1 << 13, 1 << 20), $urandom_range(1 << 17, 1 << 23),
                vrest, vth, vreset, $urandom_range(0, 10 << 16));
    end
  endtask

  task automatic run_phase(input int n);
    tick_t t;
    n_settings++;
    // two quiet integrating ticks first
    repeat (2) begin
      t = make_tick();
      t.last_spike = 32'(longint'(t.now_time) - tref_r - 1);
      t.syn_0 = '0; t.axial_0 = '0; t.elec_0 = '0;
      t.syn_1 = '0; t.axial_1 = '0; t.elec_1 = '0;
      tick_queue.push_back(t);
    end
    repeat (n) tick_queue.push_back(make_tick());
    drain();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    tick_t t;
    logic signed [31:0] base, na500, na1000;
    base = 32'sd655360;
    na500 = 32'sd32768000;
    na1000 = 32'sd65536000;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    tick_ch.valid = 1'b0;
    {tick_ch.now_time, tick_ch.prior_spike_time} = '0;
    {tick_ch.syn_current_start, tick_ch.axial_current_start} = '0;
    {tick_ch.electrode_current_start, tick_ch.syn_current_end} = '0;
    {tick_ch.axial_current_end, tick_ch.electrode_current_end} = '0;
    step_ch.ready = 1'b0;
    dt_r = DT_RST; cap_r = CAP_RST; rm_r = RM_RST;
    vrest_r = VREST_RST; vth_r = VTH_RST; vreset_r = VRESET_RST;
    tref_r = TREF_RST; vmem_r = V_INIT;
    t_cursor = 2 * base;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed ticks under the reset settings
    tick_queue.push_back(tick_of(base, 0, 0, 0, 0, 0, 0, 0));
    tick_queue.push_back(tick_of(base, base, na1000, 0, 0, na1000, 0, 0));
    tick_queue.push_back(tick_of(base + 327680, base, 0, 0, 0, 0, 0, 0));
    tick_queue.push_back(tick_of(base + 327681, base, 0, 0, 0, 0, 0, 0));
    tick_queue.push_back(tick_of(base + 400000, 0, na1000, 0, 0, na1000, 0, 0));
    tick_queue.push_back(tick_of(base + 406554, base + 400000, na1000, 0, 0, na1000, 0, 0));
    tick_queue.push_back(tick_of(2 * base, 0, SIGNED_TOP, SIGNED_TOP, SIGNED_TOP,
                                 SIGNED_TOP, SIGNED_TOP, SIGNED_TOP));
    tick_queue.push_back(tick_of(3 * base, 0, SIGNED_BOTTOM, SIGNED_BOTTOM, SIGNED_BOTTOM,
                                 SIGNED_BOTTOM, SIGNED_BOTTOM, SIGNED_BOTTOM));
    tick_queue.push_back(tick_of(SIGNED_TOP, SIGNED_BOTTOM, na500, 0, 0, na500, 0, 0));
    tick_queue.push_back(tick_of(SIGNED_BOTTOM, SIGNED_TOP, na1000, 0, 0, na1000, 0, 0));
    tick_queue.push_back(tick_of(SIGNED_BOTTOM, 0, 0, 0, 0, 0, 0, 0));
    tick_queue.push_back(tick_of(SIGNED_TOP, 0, na1000, na1000, 0, na1000, na1000, 0));
    tick_queue.push_back(tick_of(4 * base, 0, 0, 0, 0, 3 * na1000, 0, 0));
    tick_queue.push_back(tick_of(5 * base, 0, SIGNED_TOP, SIGNED_BOTTOM, na1000,
                                 SIGNED_BOTTOM, SIGNED_TOP, na1000));
    tick_queue.push_back(tick_of(6 * base, 0, -na1000, 0, na500, -na1000, 0, na500));
    tick_queue.push_back(tick_of(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                 32'hAAAA_AAAA));
    tick_queue.push_back(tick_of(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                 32'h5555_5555));
    tick_queue.push_back(tick_of(7 * base, 0, ALL_ONES, ALL_ONES, ALL_ONES,
                                 ALL_ONES, ALL_ONES, ALL_ONES));
    run_phase(120);

    // every register at its top, bit 31 of unsigned ones set and dropped
    write_all(ALL_ONES, ALL_ONES, ALL_ONES, SIGNED_TOP, SIGNED_TOP, SIGNED_TOP, ALL_ONES);
    run_phase(40);

    // bottom values: zero capacitance and resistance divide by zero
    write_all(1, 0, 0, SIGNED_BOTTOM, SIGNED_BOTTOM, SIGNED_BOTTOM, 0);
    run_phase(40);

    // threshold far below a static voltage: zero voltage difference in the ratio
    write_all(1, 32'd65536, SIGNED_TOP, 0, SIGNED_BOTTOM, 0, 0);
    for (int i = 0; i < 12; i++) begin
      t = make_tick();
      t.last_spike = t.now_time - 1;
      t.syn_0 = '0; t.axial_0 = '0; t.elec_0 = '0;
      t.syn_1 = '0; t.axial_1 = '0; t.elec_1 = '0;
      tick_queue.push_back(t);
    end
    drain();
    n_settings++;

    write_random_regs(1'b0);
    run_phase(60);

    write_random_regs(1'b0);
    write_reg(CFG_NONE, $urandom);
    no_idle = 1'b1;
    run_phase(50);
    no_idle = 1'b0;

    write_random_regs(1'b1);
    run_phase(40);

    write_all({1'b0, DT_RST}, {1'b0, CAP_RST}, {1'b0, RM_RST}, VREST_RST, VTH_RST,
              VRESET_RST, {1'b0, TREF_RST});
    run_phase(60);

    drain();
    repeat (400) @(posedge clk);
    $display("%0d ticks over %0d register settings: %0d results, %0d spikes, %0d refractory",
             n_ticks, n_settings, n_steps, n_spikes, n_held);
    if (n_bad == 0 && step_expect.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d bad results, %0d still awaited", n_bad, step_expect.size());
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      tick_ch.valid <= 1'b0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        step_expect.push_back(heun_step(tick_held));
        n_ticks++;
      end
      if (!tick_ch.valid || tick_ch.ready) begin
        if (hold_off) begin
          // sender holds until every result is back
          if (step_expect.size() == 0) hold_off = 1'b0;
          tick_ch.valid <= 1'b0;
        end else if (tick_queue.size() != 0 && (gap_left == 0 || no_idle)) begin
          tick_held = tick_queue.pop_front();
          tick_ch.now_time <= tick_held.now_time;
          tick_ch.prior_spike_time <= tick_held.last_spike;
          tick_ch.syn_current_start <= tick_held.syn_0;
          tick_ch.axial_current_start <= tick_held.axial_0;
          tick_ch.electrode_current_start <= tick_held.elec_0;
          tick_ch.syn_current_end <= tick_held.syn_1;
          tick_ch.axial_current_end <= tick_held.axial_1;
          tick_ch.electrode_current_end <= tick_held.elec_1;
          tick_ch.valid <= 1'b1;
          n_sent++;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
          if (n_sent == 40 || $urandom_range(0, 49) == 0) hold_off = 1'b1;
        end else begin
          tick_ch.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    step_t want;
    if (!rst_n) begin
      step_ch.ready <= 1'b0;
    end else begin
      if (step_ch.valid && step_ch.ready) begin
        n_steps++;
        if (step_expect.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("%t: result beat with nothing awaited: fired %0b time %0d v %0d",
                     $realtime, step_ch.fired, step_ch.fire_time, step_ch.membrane_voltage);
          end
        end else begin
          want = step_expect.pop_front();
          if (want.fired) n_spikes++;
          if (step_ch.fired !== want.fired || step_ch.fire_time !== want.fire_time ||
              step_ch.membrane_voltage !== want.vmem) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("%t: result %0d: fired %0b/%0b time %0d/%0d v %0d/%0d (got/exp)",
                       $realtime, n_steps, step_ch.fired, want.fired, step_ch.fire_time,
                       want.fire_time, step_ch.membrane_voltage, want.vmem);
            end
          end
        end
      end
      // receiver alternates ready runs and stalls, a few of them long
      if (rx_left == 0) begin
        rx_stall = !rx_stall;
        if (rx_stall) begin
          rx_left = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 400) :
                                                   $urandom_range(1, 6);
        end else begin
          rx_left = $urandom_range(1, 40);
        end
      end else begin
        rx_left--;
      end
      step_ch.ready <= no_idle || !rx_stall;
    end
  end

endmodule

>>> sim.f
sv/lnh_pkg.sv
sv/lnh_if.sv
sv/lif_neuron_heun_step.sv
verif/testbench.sv
